>>> rtl/core/tkst_pkg.sv
`default_nettype none
package tkst_pkg;

    localparam int SIZE_W   = 48;
    localparam int TAG_W    = 16;
    localparam int CAT_W    = 3;
    localparam int LIMIT_W  = 6;
    localparam int SEL_W    = 3;
    localparam int DATA_W   = 72;

    localparam int DEF_POOL_CAPACITY  = 32;
    localparam int DEF_CATEGORY_COUNT = 5;

    localparam logic [SIZE_W-1:0] THRESH_RESET = 48'd104857600;
    localparam int                LIMIT_RESET  = 32;

    localparam logic [SIZE_W-1:0] FLOOR_IMAGE = 48'd262144;
    localparam logic [SIZE_W-1:0] FLOOR_AUDIO = 48'd1048576;
    localparam logic [SIZE_W-1:0] FLOOR_OTHER = 48'd5242880;

    localparam logic [CAT_W-1:0] CAT_IMAGE = 3'd2;
    localparam logic [CAT_W-1:0] CAT_AUDIO = 3'd3;

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_LIMIT     = 1'b1;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef struct packed {
        logic              sys;
        logic [CAT_W-1:0]  cat;
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] size;
    } t_entry;

    typedef struct packed {
        t_func            func;
        logic [SEL_W-1:0] sel;
        t_entry           item;
    } t_req;

    typedef struct packed {
        logic   valid;
        t_entry item;
        logic   went_gen;
        logic   went_cat;
        logic   last;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POOL,
        ST_DECIDE,
        ST_RD_ROOT,
        ST_RD_LAST,
        ST_DN_CHK,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_DN_ODD,
        ST_UP_CHK,
        ST_UP_CMP,
        ST_RO_SCAN,
        ST_RO_LAST,
        ST_RO_EMIT,
        ST_EMIT1
    } t_state;

endpackage
`default_nettype wire

>>> rtl/core/tkst_ram.sv
`default_nettype none
module tkst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> rtl/core/tkst_ctrl.sv
`default_nettype none
module tkst_ctrl
    import tkst_pkg::*;
#(
    parameter int POOL_CAPACITY  = DEF_POOL_CAPACITY,
    parameter int CATEGORY_COUNT = DEF_CATEGORY_COUNT,
    localparam int NPOOLS = CATEGORY_COUNT + 1,
    localparam int CW     = $clog2(POOL_CAPACITY + 1),
    localparam int AW     = $clog2(NPOOLS * POOL_CAPACITY)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  wire t_req              i_req,
    input  wire logic [SIZE_W-1:0] i_threshold,
    input  wire logic [CW-1:0]     i_limit,
    output logic                   o_push,
    output t_result                o_result,
    input  wire logic              i_slot_free,
    output logic                   o_ram_we,
    output logic [AW-1:0]          o_ram_waddr,
    output t_entry                 o_ram_wdata,
    output logic [AW-1:0]          o_ram_raddr,
    input  wire t_entry            i_ram_rdata
);

    localparam int IW = $clog2(POOL_CAPACITY);
    localparam int PW = $clog2(NPOOLS);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count [NPOOLS];
    t_entry            r_new, n_new;
    t_func             r_func, n_func;
    logic              r_typed, n_typed;
    logic [PW-1:0]     r_cat_pool, n_cat_pool;
    logic [PW-1:0]     r_pool, n_pool;
    logic              r_on_cat, n_on_cat;
    logic [AW-1:0]     r_base, n_base;
    logic [CW-1:0]     r_n, n_n;
    logic [IW-1:0]     r_hole, n_hole;
    logic [IW-1:0]     r_sc, n_sc;
    logic [CW-1:0]     r_len, n_len;
    t_entry            r_v, n_v;
    t_entry            r_left, n_left;
    logic              r_pop, n_pop;
    logic              r_went_g, n_went_g;
    logic              r_went_c, n_went_c;
    logic [IW-1:0]     r_si, n_si;
    logic              r_pv, n_pv;
    logic [IW-1:0]     r_pidx, n_pidx;
    logic              r_bfound, n_bfound;
    t_entry            r_best, n_best;
    logic [IW-1:0]     r_bidx, n_bidx;
    logic              r_have_prev, n_have_prev;
    logic [SIZE_W-1:0] r_prev_size, n_prev_size;
    logic [IW-1:0]     r_prev_idx, n_prev_idx;
    logic [CW-1:0]     r_emitted, n_emitted;

    logic              w_clear, w_inc;
    logic              w_valid_cat, w_gen, w_typed, w_sel_ok;
    logic [SIZE_W-1:0] w_floor;
    logic [PW-1:0]     w_cat_pool, w_sel_pool;
    logic [IW-1:0]     w_parent;
    logic [CW-1:0]     w_sc, w_dn_lim, w_odd_pos;
    logic [CW:0]       w_two_sc;
    logic [IW-1:0]     w_left, w_right, w_last_idx;
    logic              w_elig, w_better;

    assign w_valid_cat = (i_req.item.cat != '0) && (32'(i_req.item.cat) <= CATEGORY_COUNT);
    assign w_floor     = (i_req.item.cat == CAT_IMAGE) ? FLOOR_IMAGE :
                         (i_req.item.cat == CAT_AUDIO) ? FLOOR_AUDIO : FLOOR_OTHER;
    assign w_gen       = i_req.item.size >= i_threshold;
    assign w_typed     = w_valid_cat && (i_req.item.size >= w_floor);
    assign w_sel_ok    = 32'(i_req.sel) <= CATEGORY_COUNT;
    assign w_cat_pool  = PW'(i_req.item.cat);
    assign w_sel_pool  = PW'(i_req.sel);

    assign w_parent   = (r_hole - 1'b1) >> 1;
    assign w_sc       = CW'(r_sc);
    assign w_dn_lim   = (r_len - 1'b1) >> 1;
    assign w_odd_pos  = (r_len - 2'd2) >> 1;
    assign w_two_sc   = {w_sc, 1'b0};
    assign w_left     = IW'(w_two_sc + 1'b1);
    assign w_right    = IW'(w_two_sc + 2'd2);
    assign w_last_idx = IW'(r_n - 1'b1);

    // read-out walks the pool once per word, picking the largest entry that
    // comes after the previous one in (size desc, index asc) order
    assign w_elig   = !r_have_prev || (i_ram_rdata.size < r_prev_size) ||
                      ((i_ram_rdata.size == r_prev_size) && (r_pidx > r_prev_idx));
    assign w_better = !r_bfound || (i_ram_rdata.size > r_best.size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int i = 0; i < NPOOLS; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_clear) begin
                for (int i = 0; i < NPOOLS; i++) begin
                    r_count[i] <= '0;
                end
            end else if (w_inc) begin
                r_count[r_pool] <= r_count[r_pool] + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_new       <= n_new;
        r_func      <= n_func;
        r_typed     <= n_typed;
        r_cat_pool  <= n_cat_pool;
        r_pool      <= n_pool;
        r_on_cat    <= n_on_cat;
        r_base      <= n_base;
        r_n         <= n_n;
        r_hole      <= n_hole;
        r_sc        <= n_sc;
        r_len       <= n_len;
        r_v         <= n_v;
        r_left      <= n_left;
        r_pop       <= n_pop;
        r_went_g    <= n_went_g;
        r_went_c    <= n_went_c;
        r_si        <= n_si;
        r_pv        <= n_pv;
        r_pidx      <= n_pidx;
        r_bfound    <= n_bfound;
        r_best      <= n_best;
        r_bidx      <= n_bidx;
        r_have_prev <= n_have_prev;
        r_prev_size <= n_prev_size;
        r_prev_idx  <= n_prev_idx;
        r_emitted   <= n_emitted;
    end

    always_comb begin
        n_state     = r_state;
        n_new       = r_new;
        n_func      = r_func;
        n_typed     = r_typed;
        n_cat_pool  = r_cat_pool;
        n_pool      = r_pool;
        n_on_cat    = r_on_cat;
        n_base      = r_base;
        n_n         = r_n;
        n_hole      = r_hole;
        n_sc        = r_sc;
        n_len       = r_len;
        n_v         = r_v;
        n_left      = r_left;
        n_pop       = r_pop;
        n_went_g    = r_went_g;
        n_went_c    = r_went_c;
        n_si        = r_si;
        n_pv        = r_pv;
        n_pidx      = r_pidx;
        n_bfound    = r_bfound;
        n_best      = r_best;
        n_bidx      = r_bidx;
        n_have_prev = r_have_prev;
        n_prev_size = r_prev_size;
        n_prev_idx  = r_prev_idx;
        n_emitted   = r_emitted;
        w_clear     = 1'b0;
        w_inc       = 1'b0;
        o_req_ready = 1'b0;
        o_push      = 1'b0;
        o_result    = '0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_base;
        o_ram_wdata = r_v;
        o_ram_raddr = r_base;

        if (r_pv && w_elig && w_better) begin
            n_bfound = 1'b1;
            n_best   = i_ram_rdata;
            n_bidx   = r_pidx;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_func        = i_req.func;
                    n_new.size    = i_req.item.size;
                    n_new.tag     = i_req.item.tag;
                    n_new.cat     = w_valid_cat ? i_req.item.cat : '0;
                    n_new.sys     = w_typed ? i_req.item.sys : 1'b0;
                    n_typed       = w_typed;
                    n_cat_pool    = w_cat_pool;
                    n_went_g      = 1'b0;
                    n_went_c      = 1'b0;
                    n_si          = '0;
                    n_pv          = 1'b0;
                    n_bfound      = 1'b0;
                    n_have_prev   = 1'b0;
                    n_emitted     = '0;
                    n_state       = ST_EMIT1;
                    unique case (i_req.func)
                        FUNC_INSERT: begin
                            if (w_gen) begin
                                n_pool   = '0;
                                n_on_cat = 1'b0;
                                n_state  = ST_POOL;
                            end else if (w_typed) begin
                                n_pool   = w_cat_pool;
                                n_on_cat = 1'b1;
                                n_state  = ST_POOL;
                            end
                        end
                        FUNC_READ: begin
                            if (w_sel_ok && (r_count[w_sel_pool] != '0)) begin
                                n_pool  = w_sel_pool;
                                n_state = ST_POOL;
                            end
                        end
                        FUNC_CLEAR: w_clear = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_POOL: begin
                n_base  = AW'(r_pool) * AW'(POOL_CAPACITY);
                n_n     = r_count[r_pool];
                n_state = (r_func == FUNC_READ) ? ST_RO_SCAN : ST_DECIDE;
            end
            ST_DECIDE: begin
                if (r_n < i_limit) begin
                    w_inc    = 1'b1;
                    n_hole   = IW'(r_n);
                    n_v      = r_new;
                    n_pop    = 1'b0;
                    n_went_g = r_went_g | !r_on_cat;
                    n_went_c = r_went_c | r_on_cat;
                    n_state  = ST_UP_CHK;
                end else begin
                    o_ram_raddr = r_base;
                    n_state     = ST_RD_ROOT;
                end
            end
            ST_RD_ROOT: begin
                o_ram_raddr = r_base + AW'(w_last_idx);
                if (i_ram_rdata.size >= r_new.size) begin
                    if (!r_on_cat && r_typed) begin
                        n_on_cat = 1'b1;
                        n_pool   = r_cat_pool;
                        n_state  = ST_POOL;
                    end else begin
                        n_state = ST_EMIT1;
                    end
                end else begin
                    n_went_g = r_went_g | !r_on_cat;
                    n_went_c = r_went_c | r_on_cat;
                    if (r_n >= CW'(2)) begin
                        n_state = ST_RD_LAST;
                    end else begin
                        n_hole  = '0;
                        n_v     = r_new;
                        n_pop   = 1'b0;
                        n_state = ST_UP_CHK;
                    end
                end
            end
            ST_RD_LAST: begin
                // pop: last entry is sifted down from the root of the shortened heap
                n_v     = i_ram_rdata;
                n_pop   = 1'b1;
                n_hole  = '0;
                n_sc    = '0;
                n_len   = r_n - 1'b1;
                n_state = ST_DN_CHK;
            end
            ST_DN_CHK: begin
                if (w_sc < w_dn_lim) begin
                    o_ram_raddr = r_base + AW'(w_left);
                    n_sc        = w_right;
                    n_state     = ST_DN_RDR;
                end else if (!r_len[0] && (w_sc == w_odd_pos)) begin
                    o_ram_raddr = r_base + AW'(w_left);
                    n_sc        = w_left;
                    n_state     = ST_DN_ODD;
                end else begin
                    n_state = ST_UP_CHK;
                end
            end
            ST_DN_RDR: begin
                o_ram_raddr = r_base + AW'(r_sc);
                n_left      = i_ram_rdata;
                n_state     = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_base + AW'(r_hole);
                // right child wins unless it is strictly larger
                if (i_ram_rdata.size > r_left.size) begin
                    o_ram_wdata = r_left;
                    n_hole      = r_sc - 1'b1;
                    n_sc        = r_sc - 1'b1;
                end else begin
                    o_ram_wdata = i_ram_rdata;
                    n_hole      = r_sc;
                end
                n_state = ST_DN_CHK;
            end
            ST_DN_ODD: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_base + AW'(r_hole);
                o_ram_wdata = i_ram_rdata;
                n_hole      = r_sc;
                n_state     = ST_UP_CHK;
            end
            ST_UP_CHK, ST_UP_CMP: begin
                if ((r_state == ST_UP_CHK) && (r_hole != '0)) begin
                    o_ram_raddr = r_base + AW'(w_parent);
                    n_state     = ST_UP_CMP;
                end else begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_base + AW'(r_hole);
                    if ((r_state == ST_UP_CMP) && (i_ram_rdata.size > r_v.size)) begin
                        o_ram_wdata = i_ram_rdata;
                        n_hole      = w_parent;
                        n_state     = ST_UP_CHK;
                    end else if (r_pop) begin
                        // new entry goes in at the slot left by the pop
                        o_ram_wdata = r_v;
                        n_pop       = 1'b0;
                        n_hole      = w_last_idx;
                        n_v         = r_new;
                        n_state     = ST_UP_CHK;
                    end else begin
                        o_ram_wdata = r_v;
                        if (!r_on_cat && r_typed) begin
                            n_on_cat = 1'b1;
                            n_pool   = r_cat_pool;
                            n_state  = ST_POOL;
                        end else begin
                            n_state = ST_EMIT1;
                        end
                    end
                end
            end
            ST_RO_SCAN: begin
                o_ram_raddr = r_base + AW'(r_si);
                n_pv        = 1'b1;
                n_pidx      = r_si;
                if (r_si == w_last_idx) begin
                    n_state = ST_RO_LAST;
                end else begin
                    n_si = r_si + 1'b1;
                end
            end
            ST_RO_LAST: begin
                n_pv    = 1'b0;
                n_state = ST_RO_EMIT;
            end
            ST_RO_EMIT: begin
                o_result.valid = 1'b1;
                o_result.item  = r_best;
                o_result.last  = (r_emitted == (r_n - 1'b1));
                if (i_slot_free) begin
                    o_push      = 1'b1;
                    n_have_prev = 1'b1;
                    n_prev_size = r_best.size;
                    n_prev_idx  = r_bidx;
                    n_emitted   = r_emitted + 1'b1;
                    n_si        = '0;
                    n_bfound    = 1'b0;
                    n_state     = o_result.last ? ST_IDLE : ST_RO_SCAN;
                end
            end
            ST_EMIT1: begin
                o_result.went_gen = r_went_g;
                o_result.went_cat = r_went_c;
                o_result.last     = 1'b1;
                if (i_slot_free) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_slot_free)
        else $error("result pushed into a full output slot");

    a_inc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_inc |-> (r_count[r_pool] < CW'(POOL_CAPACITY)))
        else $error("pool count grows past capacity");

    a_waddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> (32'(o_ram_waddr) < NPOOLS * POOL_CAPACITY))
        else $error("heap write outside pool storage");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |=> (r_count[0] == '0))
        else $error("clear left general pool non-empty");
`endif

endmodule
`default_nettype wire

>>> rtl/core/top_k_size_tracker_pools.sv
// Top-k size tracker: keeps the largest file entries in a general pool and
// one pool per category, each a min-heap held in a single-port-read RAM.
// s_axis: one word per command. tuser = {pool_select, func}; tdata =
// {system_flag, file_category, file_tag, size} packed as listed beside the port.
// m_axis: result words. An insert, a clear, an unknown func or a read-out of
// an empty or unknown pool gives one word; a read-out gives one word per
// entry in descending size, tlast on the final word.
// An insert that finds room sifts the entry up in each pool it goes to,
// comparing it with one parent after another, then gives its word. A full
// pool that takes the entry runs a pop (a sift down from the root of the
// shortened heap) and then a push. A read-out scans the RAM once for each
// word through its one read port.
// One command is worked at a time; the next is taken once its last word is
// in the output register. The output register lets the engine run on while
// a word waits; a stalled m_axis holds the engine when a new word is due.
// Reset clears all pool counts and loads the threshold and limit defaults;
// no clearing pass over the heap RAM is needed.
// Config writes (i_cfg_we) must only come while idle.
`default_nettype none
module top_k_size_tracker_pools
    import tkst_pkg::*;
#(
    parameter int POOL_CAPACITY  = DEF_POOL_CAPACITY,
    parameter int CATEGORY_COUNT = DEF_CATEGORY_COUNT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // size[47:0], file_tag[63:48], file_category[66:64], system_flag[67]
    input  wire logic [DATA_W-1:0] s_axis_tdata,
    // func[1:0], pool_select[4:2]
    input  wire logic [4:0]        s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // entry_size[47:0], entry_tag[63:48], entry_category[66:64],
    // entry_system[67], went_general[68], went_category[69]
    output logic [DATA_W-1:0]      m_axis_tdata,
    // entry_valid[0]
    output logic [0:0]             m_axis_tuser,
    output logic                   m_axis_tlast,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [SIZE_W-1:0] i_cfg_data
);

    localparam int NPOOLS    = CATEGORY_COUNT + 1;
    localparam int CW        = $clog2(POOL_CAPACITY + 1);
    localparam int AW        = $clog2(NPOOLS * POOL_CAPACITY);
    localparam int LIMIT_DEF = (LIMIT_RESET > POOL_CAPACITY) ? POOL_CAPACITY : LIMIT_RESET;

    logic [SIZE_W-1:0] r_threshold;
    logic [CW-1:0]     r_limit, n_limit;
    logic              r_out_valid;
    t_result           r_out;

    t_req    w_req;
    t_result w_result;
    logic    w_push, w_slot_free;
    logic    w_ram_we;
    logic [AW-1:0] w_ram_waddr, w_ram_raddr;
    t_entry  w_ram_wdata, w_ram_rdata;
    logic [31:0] w_lim_raw;

    assign w_req.func      = t_func'(s_axis_tuser[1:0]);
    assign w_req.sel       = s_axis_tuser[4:2];
    assign w_req.item.size = s_axis_tdata[47:0];
    assign w_req.item.tag  = s_axis_tdata[63:48];
    assign w_req.item.cat  = s_axis_tdata[66:64];
    assign w_req.item.sys  = s_axis_tdata[67];

    assign w_lim_raw = 32'(i_cfg_data[LIMIT_W-1:0]);

    always_comb begin
        if (w_lim_raw == 32'd0) begin
            n_limit = CW'(1);
        end else if (w_lim_raw > 32'(POOL_CAPACITY)) begin
            n_limit = CW'(POOL_CAPACITY);
        end else begin
            n_limit = CW'(w_lim_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
            r_limit     <= CW'(LIMIT_DEF);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THRESHOLD: r_threshold <= i_cfg_data;
                REG_LIMIT:     r_limit     <= n_limit;
                default: ;
            endcase
        end
    end

    assign w_slot_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.went_cat, r_out.went_gen, r_out.item.sys,
                            r_out.item.cat, r_out.item.tag, r_out.item.size};
    assign m_axis_tuser  = r_out.valid;
    assign m_axis_tlast  = r_out.last;

    tkst_ctrl #(
        .POOL_CAPACITY  (POOL_CAPACITY),
        .CATEGORY_COUNT (CATEGORY_COUNT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (w_req),
        .i_threshold (r_threshold),
        .i_limit     (r_limit),
        .o_push      (w_push),
        .o_result    (w_result),
        .i_slot_free (w_slot_free),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    tkst_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (NPOOLS * POOL_CAPACITY)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

endmodule
`default_nettype wire
